/* hw/rtl/rsx_pkg.sv */
package rsx_pkg;

  // Record layout
  localparam int REC_WORDS    = 118;
  localparam int BLOCK_WORDS  = 16;
  localparam int BLOCK_COUNT  = 4;
  localparam int SCR_WORDS    = BLOCK_COUNT * BLOCK_WORDS;
  localparam int SCR_AW       = $clog2(SCR_WORDS);
  localparam int BLK_AW       = $clog2(BLOCK_WORDS);
  localparam int IDX_W        = 7;
  localparam int WORD_W       = 16;
  localparam int SEED_W       = 32;
  localparam int LIMIT_W      = IDX_W + 1;

  localparam logic [IDX_W-1:0]   IDENT_LO     = 7'd0;
  localparam logic [IDX_W-1:0]   IDENT_HI     = 7'd1;
  localparam logic [IDX_W-1:0]   CHK_WORD     = 7'd3;
  localparam logic [IDX_W-1:0]   BLOCKS_BASE  = 7'd4;
  localparam logic [IDX_W-1:0]   PARTY_BASE   = 7'd68;
  localparam logic [IDX_W-1:0]   BLK_TOTAL    = IDX_W'(SCR_WORDS);
  localparam logic [IDX_W-1:0]   PARTY_LEN    = 7'd50;
  localparam logic [LIMIT_W-1:0] STORE_LIMIT  = LIMIT_W'(REC_WORDS);
  localparam logic [LIMIT_W-1:0] STORED_WORDS = 8'd68;
  localparam logic [LIMIT_W-1:0] PARTY_WORDS  = 8'd118;

  // Keystream generator
  localparam logic [SEED_W-1:0] LCG_MUL = 32'h41C6_4E6D;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'h0000_6073;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration registers
  localparam int         APB_AW        = 3;
  localparam logic       REG_DIRECTION = 1'b0;
  localparam logic       REG_KIND      = 1'b1;

  // Block order table: entry bits [2b+1:2b] give the source block for slot b
  localparam int PERM_ENTRIES = 24;
  localparam logic [4:0] PERM_MOD = 5'(PERM_ENTRIES);
  localparam logic [7:0] PERM_TABLE [PERM_ENTRIES] = '{
    {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0}, {2'd3, 2'd1, 2'd2, 2'd0},
    {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
    {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1}, {2'd3, 2'd0, 2'd2, 2'd1},
    {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
    {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2}, {2'd3, 2'd0, 2'd1, 2'd2},
    {2'd0, 2'd3, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
    {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
    {2'd0, 2'd2, 2'd1, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
  };

  // Keystream unit controls
  typedef struct packed {
    logic load;
    logic step;
  } lcg_ctl_t;

  // Table row from identifier bits 17:13, reduced mod 24
  function automatic logic [4:0] perm_row(input logic [4:0] raw);
    logic [4:0] res;
    res = (raw >= PERM_MOD) ? raw - PERM_MOD : raw;
    return res;
  endfunction

  // Source block for destination slot; inverse order when encrypting
  function automatic logic [1:0] src_block(input logic [4:0] row, input logic [1:0] dst,
                                           input logic enc);
    logic [7:0] entry;
    logic [1:0] res;
    entry = PERM_TABLE[row];
    res = entry[2*dst +: 2];
    if (enc) begin
      for (int b = 0; b < BLOCK_COUNT; b++) begin
        if (entry[2*b +: 2] == dst) res = 2'(b);
      end
    end
    return res;
  endfunction

endpackage

/* hw/rtl/rsx_lcg.sv */
module rsx_lcg (
  input  logic                        clk,
  input  logic                        rst,
  input  rsx_pkg::lcg_ctl_t           ctl,
  input  logic [rsx_pkg::SEED_W-1:0]  load_value,
  output logic [rsx_pkg::WORD_W-1:0]  key
);

  logic [rsx_pkg::SEED_W-1:0] seed;
  logic [rsx_pkg::SEED_W-1:0] advanced;

  // One generator step; key is the upper half of the advanced seed
  assign advanced = seed * rsx_pkg::LCG_MUL + rsx_pkg::LCG_ADD;
  assign key      = advanced[rsx_pkg::SEED_W-1 -: rsx_pkg::WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (ctl.load) begin
      seed <= load_value;
    end else if (ctl.step) begin
      seed <= advanced;
    end
  end

endmodule

/* hw/rtl/record_shuffle_xor_codec.sv */
// Record codec: keeps a record of up to 118 little-endian 16-bit words in an
// on-chip RAM (words 0-1 identifier, word 3 checksum, words 4-67 four 16-word
// blocks, words 68-117 party region). A write item gives no result; a read
// item gives its result from the registered RAM read. A process item walks
// the record one word per cycle through the single read port of each RAM:
// after the accepting cycle come the header reads, a pass from record to
// scratch, a middle step, a permuted pass back, and for a party record a
// pass over the party words, then a step to post the result. Decrypt
// (direction 0) XORs with the keystream and then unshuffles; encrypt
// (direction 1) sums words 4-67 into word 3, shuffles and XORs. The process
// result carries the checksum with tuser 1; read results carry tuser 0.
// Results queue in a two-entry buffer, so the idle input side keeps taking
// items while one result waits.
module record_shuffle_xor_codec (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // word_index[6:0], word_value[22:7]
  input  logic [1:0]                    s_tuser,   // operation[1:0]
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // data_word[15:0]
  output logic                          m_tuser,   // result_kind[0]
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsx_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_HDR    = 3'd2;
  localparam logic [2:0] ST_PASS_A = 3'd3;
  localparam logic [2:0] ST_MID    = 3'd4;
  localparam logic [2:0] ST_PASS_B = 3'd5;
  localparam logic [2:0] ST_PASS_C = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  localparam int IW = rsx_pkg::IDX_W;
  localparam int WW = rsx_pkg::WORD_W;

  // Configuration registers
  logic direction;
  logic record_kind;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {31'd0, (paddr[2] == rsx_pkg::REG_KIND) ? record_kind : direction};

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      record_kind <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        rsx_pkg::REG_DIRECTION: direction   <= pwdata[0];
        rsx_pkg::REG_KIND:      record_kind <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [1:0]    in_op;
  logic [IW-1:0] in_idx;
  logic [WW-1:0] in_val;
  logic          in_fire;
  logic          idx_stored;
  logic          idx_readable;

  assign in_op   = s_tuser;
  assign in_idx  = s_tdata[IW-1:0];
  assign in_val  = s_tdata[IW +: WW];
  assign in_fire = s_tvalid && s_tready;
  assign idx_stored   = {1'b0, in_idx} < rsx_pkg::STORE_LIMIT;
  assign idx_readable = idx_stored && ({1'b0, in_idx} <
                        (record_kind ? rsx_pkg::PARTY_WORDS : rsx_pkg::STORED_WORDS));

  // Control state
  logic [2:0]    state;
  logic [IW-1:0] cnt;
  logic          p_valid;
  logic [IW-1:0] p_idx;
  logic [31:0]   ident;
  logic [WW-1:0] chk;
  logic [WW-1:0] running_sum;
  logic [4:0]    row;
  logic          rd_zero;

  // Memories
  logic [WW-1:0] rec_mem [rsx_pkg::REC_WORDS];
  logic [WW-1:0] scr_mem [rsx_pkg::SCR_WORDS];
  logic [WW-1:0] rec_rdata;
  logic [WW-1:0] scr_rdata;
  logic          rec_we;
  logic [IW-1:0] rec_waddr;
  logic [WW-1:0] rec_wdata;
  logic [IW-1:0] rec_raddr;
  logic          scr_we;
  logic [rsx_pkg::SCR_AW-1:0] scr_waddr;
  logic [WW-1:0] scr_wdata;
  logic [rsx_pkg::SCR_AW-1:0] scr_raddr;

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    rec_rdata <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_rdata <= scr_mem[scr_raddr];
  end

  // Keystream unit
  rsx_pkg::lcg_ctl_t lcg_ctl;
  logic [31:0]       lcg_value;
  logic [WW-1:0]     key;

  rsx_lcg u_lcg (
    .clk        (clk),
    .rst        (rst),
    .ctl        (lcg_ctl),
    .load_value (lcg_value),
    .key        (key)
  );

  // Result buffer, two entries
  logic [WW:0]   rbuf [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    rcount;
  logic          push;
  logic [WW:0]   push_data;
  logic          pop;

  assign m_tvalid = rcount != 2'd0;
  assign m_tdata  = rbuf[rptr][WW-1:0];
  assign m_tuser  = rbuf[rptr][WW];
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (state == ST_IDLE) && (rcount != 2'd2);

  always_ff @(posedge clk) begin
    if (push) rbuf[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= 1'b0;
      rptr   <= 1'b0;
      rcount <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      rcount <= rcount + 2'(push) - 2'(pop);
    end
  end

  // Pass addressing
  logic          issue;
  logic [IW-1:0] pass_len;
  logic [IW-1:0] party_raddr;
  logic [IW-1:0] party_waddr;
  logic          party_wr_ok;
  logic [IW-1:0] hdr_addr;

  assign pass_len    = (state == ST_PASS_C) ? rsx_pkg::PARTY_LEN : rsx_pkg::BLK_TOTAL;
  assign issue       = cnt < pass_len;
  assign party_raddr = rsx_pkg::PARTY_BASE + cnt;
  assign party_waddr = rsx_pkg::PARTY_BASE + p_idx;
  assign party_wr_ok = {1'b0, party_waddr} < rsx_pkg::STORE_LIMIT;

  always_comb begin
    case (cnt[1:0])
      2'd0:    hdr_addr = rsx_pkg::IDENT_LO;
      2'd1:    hdr_addr = rsx_pkg::IDENT_HI;
      default: hdr_addr = rsx_pkg::CHK_WORD;
    endcase
  end

  // Memory ports, keystream control and result push
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = p_idx;
    rec_wdata = rec_rdata;
    rec_raddr = '0;
    scr_we    = 1'b0;
    scr_waddr = p_idx[rsx_pkg::SCR_AW-1:0];
    scr_wdata = rec_rdata;
    scr_raddr = '0;
    lcg_ctl   = '0;
    lcg_value = ident;
    push      = 1'b0;
    push_data = {rsx_pkg::KIND_READ, rec_rdata};
    case (state)
      ST_IDLE: begin
        rec_raddr = idx_stored ? in_idx : '0;
        rec_waddr = in_idx;
        rec_wdata = in_val;
        rec_we    = in_fire && (in_op == rsx_pkg::OP_WRITE) && idx_stored;
      end
      ST_READ: begin
        push      = 1'b1;
        push_data = {rsx_pkg::KIND_READ, rd_zero ? {WW{1'b0}} : rec_rdata};
      end
      ST_HDR: begin
        rec_raddr = hdr_addr;
        // seed for the block keystream on decrypt is the checksum word
        lcg_ctl.load = cnt == 7'd3;
        lcg_value    = {16'd0, rec_rdata};
      end
      ST_PASS_A: begin
        // record blocks to scratch: XOR on decrypt, plain copy on encrypt
        rec_raddr    = rsx_pkg::BLOCKS_BASE + cnt;
        scr_we       = p_valid;
        scr_wdata    = direction ? rec_rdata : (rec_rdata ^ key);
        lcg_ctl.step = p_valid && !direction;
      end
      ST_MID: begin
        rec_waddr    = rsx_pkg::CHK_WORD;
        rec_wdata    = running_sum;
        rec_we       = direction;
        lcg_ctl.load = direction;
        lcg_value    = {16'd0, running_sum};
      end
      ST_PASS_B: begin
        // scratch back to record in block order: XOR on encrypt
        scr_raddr    = {rsx_pkg::src_block(row, cnt[5:4], direction),
                        cnt[rsx_pkg::BLK_AW-1:0]};
        rec_waddr    = rsx_pkg::BLOCKS_BASE + p_idx;
        rec_wdata    = direction ? (scr_rdata ^ key) : scr_rdata;
        rec_we       = p_valid;
        lcg_ctl.step = p_valid && direction;
        lcg_ctl.load = !issue && record_kind;
        lcg_value    = ident;
      end
      ST_PASS_C: begin
        // party words in place; the keystream steps even past the store
        rec_raddr    = ({1'b0, party_raddr} < rsx_pkg::STORE_LIMIT) ? party_raddr : '0;
        rec_waddr    = party_waddr;
        rec_wdata    = rec_rdata ^ key;
        rec_we       = p_valid && party_wr_ok;
        lcg_ctl.step = p_valid;
      end
      ST_DONE: begin
        push      = 1'b1;
        push_data = {rsx_pkg::KIND_DONE, chk};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= ((state == ST_PASS_A) || (state == ST_PASS_B) || (state == ST_PASS_C))
                 && issue;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_fire) begin
            case (in_op)
              rsx_pkg::OP_READ:    state <= ST_READ;
              rsx_pkg::OP_PROCESS: state <= ST_HDR;
              default: ;
            endcase
          end
        end
        ST_READ: state <= ST_IDLE;
        ST_HDR: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd3) begin
            cnt   <= '0;
            state <= ST_PASS_A;
          end
        end
        ST_PASS_A: begin
          cnt <= cnt + 7'd1;
          if (!issue) begin
            cnt   <= '0;
            state <= ST_MID;
          end
        end
        ST_MID: state <= ST_PASS_B;
        ST_PASS_B: begin
          cnt <= cnt + 7'd1;
          if (!issue) begin
            cnt   <= '0;
            state <= record_kind ? ST_PASS_C : ST_DONE;
          end
        end
        ST_PASS_C: begin
          cnt <= cnt + 7'd1;
          if (!issue) begin
            cnt   <= '0;
            state <= ST_DONE;
          end
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (state == ST_HDR) begin
      running_sum <= '0;
    end else if ((state == ST_PASS_A) && p_valid && direction) begin
      running_sum <= running_sum + rec_rdata;
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= cnt;
    if (state == ST_IDLE && in_fire) rd_zero <= !idx_readable;
    if (state == ST_HDR) begin
      case (cnt[1:0])
        2'd1:    ident[15:0]  <= rec_rdata;
        2'd2:    ident[31:16] <= rec_rdata;
        2'd3: begin
          chk <= rec_rdata;
          row <= rsx_pkg::perm_row(ident[17:13]);
        end
        default: ;
      endcase
    end
    if (state == ST_MID && direction) chk <= running_sum;
  end

endmodule
